// ===== rtl/imuseq_pkg.sv =====
// ---------------------------------------------------------------------------
// IMU sample sequencer package
// Shared widths, register indexes, quantity and channel codes, reset values
// and fixed-point constants of the IMU converter sample sequencer.
// ---------------------------------------------------------------------------
package imuseq_pkg;

  // Default parameter values of the top level.
  localparam int PRESSURE_SAMPLES_DEF = 5;
  localparam int SAMPLE_BITS_DEF      = 10;

  // Port and field widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NEUTRAL_W   = 10;
  localparam int VALUE_W     = 32;
  localparam int QUANT_W     = 4;
  localparam int CHAN_W      = 3;
  localparam int BATT_W      = 16;
  localparam int PACC_W      = 16;
  localparam int MCOUNT_W    = 16;
  localparam int NFIX_FRAC   = 16;
  localparam int NFIX_W      = NEUTRAL_W + NFIX_FRAC;

  // Result bundle: up to four results per sample.
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_GYRO = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEUTRAL_X    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEUTRAL_Y    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEUTRAL_Z    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_PRESS  = 3'd4;

  // Reset values.
  localparam logic [NEUTRAL_W-1:0]      NEUTRAL_XY_RESET = 10'd512;
  localparam logic [NEUTRAL_W-1:0]      NEUTRAL_Z_RESET  = 10'd700;
  localparam logic [BATT_W-1:0]         BATTERY_RESET    = 16'd100;
  localparam logic signed [VALUE_W-1:0] PFILT_RESET      = 32'sd32000;

  // Vertical neutral tracking in 16 fractional bits (step is about 0.02).
  localparam logic [NFIX_W-1:0] NFIX_STEP = 26'd1311;
  localparam logic [NFIX_W-1:0] NFIX_HIGH = 26'(800 << NFIX_FRAC);
  localparam logic [NFIX_W-1:0] NFIX_LOW  = 26'(600 << NFIX_FRAC);

  // Divide by three as a multiply by a scaled reciprocal.
  localparam int DIV3_SHIFT = 16;
  localparam int DIV3_MUL   = 21846;

  // Quantity codes of a result beat.
  typedef enum logic [QUANT_W-1:0] {
    Q_NONE        = 4'd0,
    Q_COUNT       = 4'd1,
    Q_YAW         = 4'd2,
    Q_ROLL        = 4'd3,
    Q_PITCH       = 4'd4,
    Q_BATTERY     = 4'd5,
    Q_ACC_Y       = 4'd6,
    Q_ACC_X       = 4'd7,
    Q_ACC_Z_CORR  = 4'd8,
    Q_ACC_Z_RAW   = 4'd9,
    Q_INTEGRAL    = 4'd10,
    Q_PRESS_RAW   = 4'd11,
    Q_PRESS_FILT  = 4'd12,
    Q_HEIGHT      = 4'd13,
    Q_HEIGHT_RATE = 4'd14
  } quantity_t;

  // Converter channel codes.
  typedef enum logic [CHAN_W-1:0] {
    CH_YAW      = 3'd0,
    CH_ROLL     = 3'd1,
    CH_PITCH    = 3'd2,
    CH_PRESSURE = 3'd3,
    CH_BATTERY  = 3'd4,
    CH_ACC_Z    = 3'd5,
    CH_ACC_Y    = 3'd6,
    CH_ACC_X    = 3'd7
  } channel_t;

  // One result held in the output bundle.
  typedef struct packed {
    quantity_t                  quantity;
    logic signed [VALUE_W-1:0]  value;
  } result_t;

endpackage

// ===== rtl/imu_adc_sample_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// IMU converter sample sequencer
// Walks the eleven-step channel sequence, one converter sample per step,
// and turns each sample into one to four result beats.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, sample) takes one converter
// result per beat; the output channel (out_valid, out_ready and the result
// fields) returns the results that sample causes, the final one with last
// set. Every result beat carries the channel to convert next and the
// restart flag. Registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it. Writing the vertical neutral also
// reloads the tracked neutral. A sample is captured in the input register,
// is processed in one pass into the result bundle register, and its first
// result shows from that register.
// Throughput: one sample per cycle while each sample yields one result
// and out_ready stays high. The bundle register drains one result beat per
// cycle while out_ready is high, so the vertical acceleration step and a
// completed pressure batch hold the pipe until their last beat is taken.
// Reset restores all filters, the step counter and the registers to their
// reset values and empties both stages. When the receiver stalls, the
// bundle holds, the input register fills and in_ready drops.
// ---------------------------------------------------------------------------
module imu_adc_sample_sequencer_core
  import imuseq_pkg::*;
#(
  parameter int PRESSURE_SAMPLES = PRESSURE_SAMPLES_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [QUANT_W-1:0]        quantity,
  output logic signed [VALUE_W-1:0] value,
  output logic                      last,
  output logic [CHAN_W-1:0]         next_channel,
  output logic                      restart_conversion
);

  localparam int ACC_W    = SAMPLE_BITS + 1;
  localparam int GYRO_W   = SAMPLE_BITS + 1;
  localparam int PROD_W   = SAMPLE_BITS + 15;
  localparam int THIRD_W  = PROD_W - DIV3_SHIFT;
  localparam int BSUM_W   = BATT_W + 2;
  localparam int D_W      = SAMPLE_BITS + NFIX_FRAC + 1;
  localparam int PCOUNT_W = $clog2(PRESSURE_SAMPLES + 1);

  typedef enum logic [3:0] {
    ST_YAW_FIRST   = 4'd0,
    ST_ROLL_FIRST  = 4'd1,
    ST_PITCH_FIRST = 4'd2,
    ST_BATTERY     = 4'd3,
    ST_ACC_Y       = 4'd4,
    ST_ACC_X       = 4'd5,
    ST_YAW_PAIR    = 4'd6,
    ST_ROLL_PAIR   = 4'd7,
    ST_PITCH_PAIR  = 4'd8,
    ST_ACC_Z       = 4'd9,
    ST_PRESSURE    = 4'd10
  } step_t;

  // Input register.
  logic                   in_full;
  logic [SAMPLE_BITS-1:0] sample_q;

  // Configuration registers.
  logic                     avg_mode;
  logic [NEUTRAL_W-1:0]     neutral_x;
  logic [NEUTRAL_W-1:0]     neutral_y;
  logic signed [PACC_W-1:0] start_pressure;

  // Sequencer and filter state.
  step_t                      step, step_next;
  logic [SAMPLE_BITS-1:0]     gyro_first [3];
  logic [BATT_W-1:0]          battery, battery_next;
  logic signed [ACC_W-1:0]    acc_lat, acc_lat_next;
  logic signed [ACC_W-1:0]    acc_lon, acc_lon_next;
  logic [NFIX_W-1:0]          nfix, nfix_next;
  logic signed [VALUE_W-1:0]  vint, vint_next;
  logic signed [PACC_W-1:0]   pacc, pacc_next;
  logic [PCOUNT_W-1:0]        pcount, pcount_next;
  logic signed [VALUE_W-1:0]  pfilt, pfilt_next;
  logic signed [VALUE_W-1:0]  height, height_next;
  logic [MCOUNT_W-1:0]        mcount, mcount_next;

  // Result bundle register.
  logic                 res_valid;
  result_t              res [MAX_RESULTS];
  logic [RES_IDX_W-1:0] res_idx;
  logic [RES_IDX_W-1:0] res_last_idx;
  channel_t             res_chan;
  logic                 res_restart;

  // Bundle built in this pass.
  result_t              bun [MAX_RESULTS];
  logic [RES_IDX_W-1:0] bun_last_idx;
  channel_t             bun_chan;

  // Datapath intermediates.
  logic [PROD_W-1:0]          s_prod;
  logic [THIRD_W-1:0]         s_third;
  logic [BSUM_W-1:0]          batt_sum;
  logic [SAMPLE_BITS-1:0]     gyro_sel;
  logic [GYRO_W-1:0]          gyro_sum;
  logic [GYRO_W-1:0]          gyro_val;
  logic signed [D_W-1:0]      d;
  logic signed [D_W-17:0]     d_hi;
  logic [ACC_W-1:0]           ay;
  logic [ACC_W-1:0]           ax;
  logic signed [VALUE_W-1:0]  corr;
  logic signed [VALUE_W-1:0]  vint_sum;
  logic signed [VALUE_W-1:0]  vint_leak;
  logic signed [PACC_W-1:0]   pacc_sum;
  logic [PCOUNT_W-1:0]        pcount_inc;
  logic                       batch_done;
  logic signed [VALUE_W-1:0]  f_sum;
  logic signed [VALUE_W-1:0]  pfilt_new;
  logic signed [VALUE_W-1:0]  height_new;
  logic signed [VALUE_W-1:0]  rate;

  // Handshake control.
  logic    out_last;
  logic    fire;
  result_t cur;

  assign cur       = res[res_idx];
  assign out_last  = (res_idx == res_last_idx);
  assign fire      = in_full && (!res_valid || (out_ready && out_last));
  assign in_ready  = !in_full || fire;

  assign out_valid          = res_valid;
  assign quantity           = cur.quantity;
  assign value              = cur.value;
  assign last               = out_last;
  assign next_channel       = res_chan;
  assign restart_conversion = res_restart;

  // Arithmetic shared by the steps.
  always_comb begin
    // Battery low-pass: (3 * old + sample / 3) / 4.
    s_prod   = PROD_W'(sample_q) * PROD_W'(DIV3_MUL);
    s_third  = s_prod[PROD_W-1:DIV3_SHIFT];
    batt_sum = BSUM_W'({battery, 1'b0}) + BSUM_W'(battery) + BSUM_W'(s_third);

    // Gyro pair sum or floor average.
    case (step)
      ST_YAW_PAIR:  gyro_sel = gyro_first[0];
      ST_ROLL_PAIR: gyro_sel = gyro_first[1];
      default:      gyro_sel = gyro_first[2];
    endcase
    gyro_sum = GYRO_W'(sample_q) + GYRO_W'(gyro_sel);
    gyro_val = avg_mode ? (gyro_sum >> 1) : gyro_sum;

    // Vertical difference against the neutral, truncated toward zero.
    d    = $signed({1'b0, sample_q, {NFIX_FRAC{1'b0}}}) - $signed(D_W'(nfix));
    d_hi = d[D_W-1:NFIX_FRAC];
    ay   = acc_lat[ACC_W-1] ? ACC_W'(-acc_lat) : ACC_W'(acc_lat);
    ax   = acc_lon[ACC_W-1] ? ACC_W'(-acc_lon) : ACC_W'(acc_lon);
    corr = VALUE_W'(d_hi) + VALUE_W'(d[D_W-1] && (|d[NFIX_FRAC-1:0]))
         + VALUE_W'(ay >> 2) + VALUE_W'(ax >> 2);

    // Leaky integral: add, then remove 1/1024 truncated toward zero.
    vint_sum  = vint + corr;
    vint_leak = (vint_sum >>> 10)
              + $signed(VALUE_W'(vint_sum[VALUE_W-1] && (|vint_sum[9:0])));

    // Pressure batch.
    pacc_sum   = pacc + PACC_W'(sample_q);
    pcount_inc = pcount + PCOUNT_W'(1);
    batch_done = (pcount_inc >= PCOUNT_W'(PRESSURE_SAMPLES));
    f_sum      = VALUE_W'(pacc_sum) + (pfilt <<< 1) + pfilt;
    pfilt_new  = (f_sum >>> 2) + $signed(VALUE_W'(f_sum[VALUE_W-1] && (|f_sum[1:0])));
    height_new = VALUE_W'(start_pressure) - pfilt_new;
    rate       = VALUE_W'(start_pressure) - VALUE_W'(pacc_sum) - height;
  end

  // Step decode: next state and the result bundle of this sample.
  always_comb begin
    step_next    = ST_YAW_FIRST;
    battery_next = battery;
    acc_lat_next = acc_lat;
    acc_lon_next = acc_lon;
    nfix_next    = nfix;
    vint_next    = vint;
    pacc_next    = pacc;
    pcount_next  = pcount;
    pfilt_next   = pfilt;
    height_next  = height;
    mcount_next  = mcount;
    bun_last_idx = '0;
    bun_chan     = CH_YAW;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bun[i] = '{quantity: Q_NONE, value: '0};
    end

    unique case (step)
      ST_YAW_FIRST: begin
        step_next   = ST_ROLL_FIRST;
        bun_chan    = CH_ROLL;
        mcount_next = mcount + MCOUNT_W'(1);
        bun[0]      = '{quantity: Q_COUNT, value: VALUE_W'(mcount_next)};
      end
      ST_ROLL_FIRST: begin
        step_next = ST_PITCH_FIRST;
        bun_chan  = CH_PITCH;
      end
      ST_PITCH_FIRST: begin
        step_next = ST_BATTERY;
        bun_chan  = CH_BATTERY;
      end
      ST_BATTERY: begin
        step_next    = ST_ACC_Y;
        bun_chan     = CH_ACC_Y;
        battery_next = batt_sum[BSUM_W-1:2];
        bun[0]       = '{quantity: Q_BATTERY, value: VALUE_W'(battery_next)};
      end
      ST_ACC_Y: begin
        step_next    = ST_ACC_X;
        bun_chan     = CH_ACC_X;
        acc_lat_next = $signed(ACC_W'(neutral_y) - ACC_W'(sample_q));
        bun[0]       = '{quantity: Q_ACC_Y, value: VALUE_W'(acc_lat_next)};
      end
      ST_ACC_X: begin
        step_next    = ST_YAW_PAIR;
        bun_chan     = CH_YAW;
        acc_lon_next = $signed(ACC_W'(sample_q) - ACC_W'(neutral_x));
        bun[0]       = '{quantity: Q_ACC_X, value: VALUE_W'(acc_lon_next)};
      end
      ST_YAW_PAIR: begin
        step_next = ST_ROLL_PAIR;
        bun_chan  = CH_ROLL;
        bun[0]    = '{quantity: Q_YAW, value: VALUE_W'(gyro_val)};
      end
      ST_ROLL_PAIR: begin
        step_next = ST_PITCH_PAIR;
        bun_chan  = CH_PITCH;
        bun[0]    = '{quantity: Q_ROLL, value: VALUE_W'(gyro_val)};
      end
      ST_PITCH_PAIR: begin
        step_next = ST_ACC_Z;
        bun_chan  = CH_ACC_Z;
        bun[0]    = '{quantity: Q_PITCH, value: VALUE_W'(gyro_val)};
      end
      ST_ACC_Z: begin
        step_next = ST_PRESSURE;
        bun_chan  = CH_PRESSURE;
        // Neutral creeps toward the sample, held near its bounds.
        if (corr > 32'sd1) begin
          if (nfix < NFIX_HIGH) begin
            nfix_next = nfix + NFIX_STEP;
          end
        end else if (corr < -32'sd1) begin
          if (nfix > NFIX_LOW) begin
            nfix_next = nfix - NFIX_STEP;
          end
        end
        vint_next    = vint_sum - vint_leak;
        bun[0]       = '{quantity: Q_ACC_Z_CORR, value: corr};
        bun[1]       = '{quantity: Q_ACC_Z_RAW, value: VALUE_W'(sample_q)};
        bun[2]       = '{quantity: Q_INTEGRAL, value: vint_next};
        bun_last_idx = RES_IDX_W'(2);
      end
      ST_PRESSURE: begin
        step_next = ST_YAW_FIRST;
        bun_chan  = CH_YAW;
        if (batch_done) begin
          pcount_next  = '0;
          pacc_next    = '0;
          pfilt_next   = pfilt_new;
          height_next  = height_new;
          bun[0]       = '{quantity: Q_PRESS_RAW, value: VALUE_W'(sample_q)};
          bun[1]       = '{quantity: Q_PRESS_FILT, value: pfilt_new};
          bun[2]       = '{quantity: Q_HEIGHT, value: height_new};
          bun[3]       = '{quantity: Q_HEIGHT_RATE, value: rate};
          bun_last_idx = RES_IDX_W'(3);
        end else begin
          pcount_next = pcount_inc;
          pacc_next   = pacc_sum;
        end
      end
      default: begin
        // Unused step codes fall back to the start of the sequence.
        step_next = ST_YAW_FIRST;
        bun_chan  = CH_YAW;
      end
    endcase
  end

  // Input register, sequencer state, result bundle and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      res_valid      <= 1'b0;
      res_idx        <= '0;
      res_last_idx   <= '0;
      res_chan       <= CH_YAW;
      res_restart    <= 1'b0;
      avg_mode       <= 1'b0;
      neutral_x      <= NEUTRAL_XY_RESET;
      neutral_y      <= NEUTRAL_XY_RESET;
      start_pressure <= '0;
      step           <= ST_YAW_FIRST;
      gyro_first[0]  <= '0;
      gyro_first[1]  <= '0;
      gyro_first[2]  <= '0;
      battery        <= BATTERY_RESET;
      acc_lat        <= '0;
      acc_lon        <= '0;
      nfix           <= {NEUTRAL_Z_RESET, {NFIX_FRAC{1'b0}}};
      vint           <= '0;
      pacc           <= '0;
      pcount         <= '0;
      pfilt          <= PFILT_RESET;
      height         <= '0;
      mcount         <= '0;
    end else begin
      // Input beat capture.
      if (in_valid && in_ready) begin
        in_full  <= 1'b1;
        sample_q <= sample;
      end else if (fire) begin
        in_full <= 1'b0;
      end

      // Result bundle: load on a pass, otherwise drain one beat at a time.
      if (fire) begin
        res_valid    <= 1'b1;
        res          <= bun;
        res_idx      <= '0;
        res_last_idx <= bun_last_idx;
        res_chan     <= bun_chan;
        res_restart  <= (step_next != ST_YAW_FIRST);
      end else if (res_valid && out_ready) begin
        if (out_last) begin
          res_valid <= 1'b0;
        end else begin
          res_idx <= res_idx + RES_IDX_W'(1);
        end
      end

      // State update for the processed sample.
      if (fire) begin
        step    <= step_next;
        battery <= battery_next;
        acc_lat <= acc_lat_next;
        acc_lon <= acc_lon_next;
        nfix    <= nfix_next;
        vint    <= vint_next;
        pacc    <= pacc_next;
        pcount  <= pcount_next;
        pfilt   <= pfilt_next;
        height  <= height_next;
        mcount  <= mcount_next;
        case (step)
          ST_YAW_FIRST:   gyro_first[0] <= sample_q;
          ST_ROLL_FIRST:  gyro_first[1] <= sample_q;
          ST_PITCH_FIRST: gyro_first[2] <= sample_q;
          default:        ;
        endcase
      end

      // Register writes; the vertical neutral write reloads the tracker.
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_AVERAGE_GYRO: avg_mode       <= cfg_data[0];
          CFG_NEUTRAL_X:    neutral_x      <= cfg_data[NEUTRAL_W-1:0];
          CFG_NEUTRAL_Y:    neutral_y      <= cfg_data[NEUTRAL_W-1:0];
          CFG_NEUTRAL_Z:    nfix           <= {cfg_data[NEUTRAL_W-1:0], {NFIX_FRAC{1'b0}}};
          CFG_START_PRESS:  start_pressure <= $signed(cfg_data[PACC_W-1:0]);
          default:          ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_imu_adc_sample_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// IMU sample sequencer testbench
// Feeds converter samples through the eleven-step channel sequence under
// several register settings. An internal model tracks the step, filters,
// neutral tracking and pressure batch, and checks every result beat in
// order. Both handshakes are throttled at random, with one long output
// stall that backs the block up into its input.
// ---------------------------------------------------------------------------
module tb_imu_adc_sample_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import imuseq_pkg::*;

  localparam int unsigned ZERO_G_STEP_FIX = 1311;
  localparam int unsigned ZERO_G_HIGH_FIX = 800 << 16;
  localparam int unsigned ZERO_G_LOW_FIX  = 600 << 16;
  localparam int unsigned PRESSURE_BATCH  = 5;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int PHASES       = 6;

  typedef struct {
    quantity_t         quantity;
    logic signed [31:0] value;
    logic              last;
    channel_t          next_channel;
    logic              restart;
  } imu_result_t;

  typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_EVERY_THIRD} ready_mode_t;

  // Tracks the sequencer state and holds the result beats still owed.
  class imu_sequence_scoreboard;
    bit          avg_pairs;
    logic [9:0]  neutral_x;
    logic [9:0]  neutral_y;
    int          start_press;
    int unsigned step_idx;
    logic [9:0]  gyro_first [3];
    int unsigned battery;
    int          acc_lat;
    int          acc_long;
    int unsigned zero_g_fix;
    int          vert_integral;
    shortint     press_acc;
    int unsigned press_count;
    int          press_filt;
    int          height;
    int unsigned meas_count;
    int          errors;
    imu_result_t expected_results[$];
    imu_result_t step_results[$];

    function new();
      avg_pairs = 0;
      neutral_x = 512;
      neutral_y = 512;
      start_press = 0;
      step_idx = 0;
      foreach (gyro_first[k]) gyro_first[k] = '0;
      battery = 100;
      acc_lat = 0;
      acc_long = 0;
      zero_g_fix = 700 << 16;
      vert_integral = 0;
      press_acc = 0;
      press_count = 0;
      press_filt = 32000;
      height = 0;
      meas_count = 0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_AVERAGE_GYRO: avg_pairs = data[0];
        CFG_NEUTRAL_X:    neutral_x = data[9:0];
        CFG_NEUTRAL_Y:    neutral_y = data[9:0];
        // Writing the start neutral also reloads the tracked neutral.
        CFG_NEUTRAL_Z:    zero_g_fix = 32'(data[9:0]) << 16;
        CFG_START_PRESS:  start_press = int'(signed'(data));
        default: ;
      endcase
    endfunction

    function void add_result(quantity_t q, logic signed [31:0] v);
      imu_result_t r;
      r.quantity = q;
      r.value = v;
      r.last = 1'b0;
      r.next_channel = CH_YAW;
      r.restart = 1'b0;
      step_results.push_back(r);
    endfunction

    function logic [31:0] pair_gyro(logic [9:0] a, logic [9:0] b);
      int unsigned sum;
      sum = 32'(a) + 32'(b);
      return avg_pairs ? sum / 2 : sum;
    endfunction

    // Advances the sequence by one sample and queues the beats it causes.
    function void note_sample(logic [9:0] s);
      int unsigned cur;
      channel_t    chan;
      longint      diff;
      longint      corr;
      int          abs_y;
      int          abs_x;
      int          sum_p;
      int          rate;
      cur = step_idx;
      step_idx = (step_idx + 1) & 15;
      step_results.delete();
      chan = CH_YAW;
      case (cur)
        0: begin
          gyro_first[0] = s;
          chan = CH_ROLL;
          meas_count = (meas_count + 1) & 32'hFFFF;
          add_result(Q_COUNT, meas_count);
        end
        1: begin
          gyro_first[1] = s;
          chan = CH_PITCH;
          add_result(Q_NONE, 0);
        end
        2: begin
          gyro_first[2] = s;
          chan = CH_BATTERY;
          add_result(Q_NONE, 0);
        end
        3: begin
          battery = ((3 * battery + 32'(s) / 3) / 4) & 32'hFFFF;
          chan = CH_ACC_Y;
          add_result(Q_BATTERY, battery);
        end
        4: begin
          acc_lat = int'(neutral_y) - int'(s);
          chan = CH_ACC_X;
          add_result(Q_ACC_Y, acc_lat);
        end
        5: begin
          acc_long = int'(s) - int'(neutral_x);
          chan = CH_YAW;
          add_result(Q_ACC_X, acc_long);
        end
        6: begin
          chan = CH_ROLL;
          add_result(Q_YAW, pair_gyro(s, gyro_first[0]));
        end
        7: begin
          chan = CH_PITCH;
          add_result(Q_ROLL, pair_gyro(s, gyro_first[1]));
        end
        8: begin
          chan = CH_ACC_Z;
          add_result(Q_PITCH, pair_gyro(s, gyro_first[2]));
        end
        9: begin
          // Tilt correction: whole part of the difference, rounded toward zero.
          diff = (longint'(s) << 16) - longint'(zero_g_fix);
          corr = (diff >= 0) ? (diff >>> 16) : -((-diff) >>> 16);
          abs_y = (acc_lat < 0) ? -acc_lat : acc_lat;
          abs_x = (acc_long < 0) ? -acc_long : acc_long;
          corr = corr + abs_y / 4 + abs_x / 4;
          // The neutral creeps toward the sample, bounded on the side it moves to.
          if (corr > 1) begin
            if (zero_g_fix < ZERO_G_HIGH_FIX) zero_g_fix = zero_g_fix + ZERO_G_STEP_FIX;
          end else if (corr < -1) begin
            if (zero_g_fix > ZERO_G_LOW_FIX) zero_g_fix = zero_g_fix - ZERO_G_STEP_FIX;
          end
          vert_integral = vert_integral + int'(corr);
          vert_integral = vert_integral - vert_integral / 1024;
          chan = CH_PRESSURE;
          add_result(Q_ACC_Z_CORR, 32'(corr));
          add_result(Q_ACC_Z_RAW, s);
          add_result(Q_INTEGRAL, vert_integral);
        end
        10: begin
          press_acc = press_acc + shortint'(s);
          press_count++;
          if (press_count >= PRESSURE_BATCH) begin
            rate = start_press - int'(press_acc) - height;
            sum_p = int'(press_acc) + 3 * press_filt;
            press_count = 0;
            press_filt = sum_p / 4;
            height = start_press - press_filt;
            press_acc = 0;
            add_result(Q_PRESS_RAW, s);
            add_result(Q_PRESS_FILT, press_filt);
            add_result(Q_HEIGHT, height);
            add_result(Q_HEIGHT_RATE, rate);
          end else begin
            add_result(Q_NONE, 0);
          end
          chan = CH_YAW;
          step_idx = 0;
        end
        default: begin
          chan = CH_YAW;
          step_idx = 0;
          add_result(Q_NONE, 0);
        end
      endcase
      foreach (step_results[k]) begin
        step_results[k].last = (k == step_results.size() - 1);
        step_results[k].next_channel = chan;
        step_results[k].restart = (step_idx != 0);
        expected_results.push_back(step_results[k]);
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compares one result beat with the oldest one owed.
    task check_result(logic [3:0] q, logic signed [31:0] v, logic l, logic [2:0] ch,
                      logic rs);
      imu_result_t e;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: quantity %0d value %0d", q, v));
        return;
      end
      e = expected_results.pop_front();
      if (q !== e.quantity)
        report_mismatch($sformatf("quantity %0d, expected %0d", q, e.quantity));
      if (v !== e.value)
        report_mismatch($sformatf("quantity %0d: value %0d, expected %0d",
                                  e.quantity, v, e.value));
      if (l !== e.last)
        report_mismatch($sformatf("quantity %0d: last %b, expected %b",
                                  e.quantity, l, e.last));
      if (ch !== e.next_channel)
        report_mismatch($sformatf("quantity %0d: next channel %0d, expected %0d",
                                  e.quantity, ch, e.next_channel));
      if (rs !== e.restart)
        report_mismatch($sformatf("quantity %0d: restart %b, expected %b",
                                  e.quantity, rs, e.restart));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [9:0]                sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [QUANT_W-1:0]        quantity;
  logic signed [VALUE_W-1:0] value;
  logic                      last;
  logic [CHAN_W-1:0]         next_channel;
  logic                      restart_conversion;

  imu_sequence_scoreboard sb;
  bit long_hold_request = 1'b0;
  int burst_left = 0;
  int stalled_cycles = 0;

  imu_adc_sample_sequencer_core dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .sample             (sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .quantity           (quantity),
    .value              (value),
    .last               (last),
    .next_channel       (next_channel),
    .restart_conversion (restart_conversion)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Sends one sample beat; bursts of random length are split by random gaps.
  task send_sample(input logic [9:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Stops offering samples and waits until every owed beat has come back.
  task drain_results();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes one register; cfg_write stays high for back-to-back writes.
  task write_register(input logic [CFG_INDEX_W-1:0] index,
                      input logic [CFG_DATA_W-1:0] data, input bit may_skip);
    if (!may_skip || $urandom_range(0, 1) == 1) begin
      cfg_write <= 1'b1;
      cfg_index <= index;
      cfg_data <= data;
      @(posedge clk);
      sb.set_register(index, data);
    end
  endtask

  task program_registers(input bit avg, input logic [9:0] nx, input logic [9:0] ny,
                         input logic [9:0] nz, input int sp, input bit may_skip);
    write_register(CFG_AVERAGE_GYRO, 16'(avg), may_skip);
    write_register(CFG_NEUTRAL_X, 16'(nx), may_skip);
    write_register(CFG_NEUTRAL_Y, 16'(ny), may_skip);
    write_register(CFG_NEUTRAL_Z, 16'(nz), may_skip);
    write_register(CFG_START_PRESS, 16'(sp), may_skip);
    cfg_write <= 1'b0;
  endtask

  // Main sequence: directed sweep, then random phases under new settings.
  initial begin
    // Two full sequences: high samples but for a low lateral one, then low
    // samples with level horizontal ones, a quiet vertical one and mixed gyro pairs.
    logic [9:0] directed_samples [22] = '{
      1023, 1023, 1023, 1023, 0, 1023, 1023, 1023, 1023, 1023, 1023,
      0, 0, 0, 0, 512, 512, 1023, 1023, 1023, 700, 0
    };
    logic [9:0] s;
    int p;
    int k;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_samples[k]) send_sample(directed_samples[k]);
    drain_results();
    for (p = 1; p <= PHASES; p++) begin
      case (p)
        1: program_registers(1'b1, 10'd0, 10'd1023, 10'd600, -32768, 1'b0);
        2: program_registers(1'b0, 10'd1023, 10'd0, 10'd800, 32767, 1'b0);
        3: program_registers(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             10'd0, $urandom_range(0, 65535), 1'b0);
        4: program_registers(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             10'd1023, $urandom_range(0, 65535), 1'b0);
        default: program_registers($urandom_range(0, 1), $urandom_range(0, 1023),
                                   $urandom_range(0, 1023), $urandom_range(600, 800),
                                   $urandom_range(0, 65535), 1'b1);
      endcase
      // Hold the output off for a while so the block backs up into its input.
      if (p == 2) long_hold_request = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 7))
          0: s = 10'd0;
          1: s = 10'd1023;
          default: s = $urandom_range(0, 1023);
        endcase
        send_sample(s);
      end
      drain_results();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_imu_adc_sample_sequencer_core passed");
    end else begin
      $display("tb_imu_adc_sample_sequencer_core failed");
    end
    $finish;
  end

  // Output throttling: a random ready pattern that changes at random
  // intervals, plus the requested long hold.
  initial begin
    ready_mode_t mode;
    int mode_left;
    int tick;
    mode = READY_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        tick++;
        case (mode)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Every accepted result beat is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(quantity, value, last, next_channel, restart_conversion);
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("tb_imu_adc_sample_sequencer_core failed");
      $finish;
    end
  end

endmodule
